/* sv/sfr_pkg.sv */
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared types and constants for the serial frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package sfr_pkg;

   localparam int MAX_PAYLOAD = 64;
   localparam int CNT_W       = 7;
   localparam int IDX_W       = 6;
   localparam int SHORT_LEN   = 3;

   localparam logic [7:0] CH_V   = 8'h56;
   localparam logic [7:0] CH_AT  = 8'h40;
   localparam logic [7:0] CH_ONE = 8'h31;
   localparam logic [7:0] CH_W   = 8'h57;
   localparam logic [7:0] CH_D   = 8'h44;
   localparam logic [7:0] CH_F   = 8'h46;
   localparam logic [7:0] CH_4   = 8'h34;
   localparam logic [7:0] CH_LF  = 8'h66;
   localparam logic [7:0] CH_LB  = 8'h62;
   localparam logic [7:0] CH_LL  = 8'h6c;
   localparam logic [7:0] CH_LR  = 8'h72;
   localparam logic [7:0] CH_LW  = 8'h77;
   localparam logic [7:0] CH_LS  = 8'h73;

   typedef enum logic [2:0] {
      ST_HEADER,
      ST_VERSION,
      ST_LENGTH,
      ST_DATA,
      ST_CHECK,
      ST_SHORT,
      ST_FETCH,
      ST_EMIT
   } state_type;

   typedef enum logic [2:0] {
      ERR_HEADER   = 3'd0,
      ERR_VERSION  = 3'd1,
      ERR_LENGTH   = 3'd2,
      ERR_CHECKSUM = 3'd3,
      ERR_SHORT    = 3'd4
   } err_code_type;

   typedef struct packed {
      logic         load_len;
      logic         store_byte;
      logic         short_start;
      logic         short_byte;
      logic         clr_count;
      logic         start_replay;
      logic         replay_short;
      logic         emit_err;
      err_code_type err_code;
      logic         emit_payload;
   } cmd_type;

   typedef struct packed {
      logic is_v;
      logic is_at;
      logic is_one;
      logic len_big;
      logic len_zero;
      logic frame_len_zero;
      logic sum_ok;
      logic data_done;
      logic data_full;
      logic short_done;
      logic short_good;
      logic replay_last;
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

/* sv/sfr_ram.sv */
// ----------------------------------------------------------------------------
// sfr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sfr_ram #(
   parameter int Width = 8,
   parameter int Depth = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic      [Width-1:0]         rd_data
);

   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* sv/sfr_dpath.sv */
// ----------------------------------------------------------------------------
// sfr_dpath
// Datapath: length, count and checksum registers, payload buffer, replay
// index and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module sfr_dpath #(
   parameter int MaxPayload = sfr_pkg::MAX_PAYLOAD
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic [7:0]          rx_byte,
   input  wire sfr_pkg::cmd_type    cmd,
   output sfr_pkg::status_type      status,
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   output logic [23:0]              rsp_tdata,   // payload_byte, byte_index, short_frame, error_code
   output logic                     rsp_tuser,   // out_kind
   output logic                     rsp_tlast
);

   import sfr_pkg::*;

   localparam int AddrW = $clog2(MaxPayload);

   logic [CNT_W-1:0] len_ff, len_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [7:0]       sum_ff, sum_in;
   logic             ok_ff, ok_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] rep_cnt_ff, rep_cnt_in;
   logic             rep_short_ff, rep_short_in;

   logic             valid_ff, valid_in;
   logic             kind_ff, kind_in;
   logic [7:0]       data_ff, data_in;
   logic [IDX_W-1:0] oidx_ff, oidx_in;
   logic             oshort_ff, oshort_in;
   err_code_type     code_ff, code_in;
   logic             last_ff, last_in;

   logic             ram_we;
   logic [7:0]       ram_rd;
   logic             chk_a, chk_b, chk_c, chk_pos;

   sfr_ram #(
      .Width (8),
      .Depth (MaxPayload)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (cnt_ff[AddrW-1:0]),
      .wr_data (rx_byte),
      .rd_addr (idx_ff[AddrW-1:0]),
      .rd_data (ram_rd)
   );

   assign ram_we = cmd.store_byte || cmd.short_byte;

   always_comb begin
      chk_a = (rx_byte == CH_W) || (rx_byte == CH_D) || (rx_byte == CH_F);
      chk_b = (rx_byte >= CH_ONE) && (rx_byte <= CH_4);
      chk_c = (rx_byte == CH_LF) || (rx_byte == CH_LB) || (rx_byte == CH_LL) ||
              (rx_byte == CH_LR) || (rx_byte == CH_LW) || (rx_byte == CH_LS);
      case (cnt_ff[1:0])
         2'd0:    chk_pos = chk_a;
         2'd1:    chk_pos = chk_b;
         default: chk_pos = chk_c;
      endcase
   end

   always_comb begin
      status.is_v           = (rx_byte == CH_V);
      status.is_at          = (rx_byte == CH_AT);
      status.is_one         = (rx_byte == CH_ONE);
      status.len_big        = (rx_byte > 8'(MaxPayload));
      status.len_zero       = (rx_byte == 8'd0);
      status.frame_len_zero = (len_ff == '0);
      status.sum_ok         = (sum_ff == rx_byte);
      status.data_done      = ((cnt_ff + CNT_W'(1)) == len_ff);
      status.data_full      = (cnt_ff >= CNT_W'(MaxPayload));
      status.short_done     = (cnt_ff == CNT_W'(SHORT_LEN - 1));
      status.short_good     = ok_ff && chk_pos;
      status.replay_last    = (({1'b0, idx_ff} + CNT_W'(1)) == rep_cnt_ff);
      status.out_free       = !valid_ff || rsp_tready;
   end

   always_comb begin
      len_in       = len_ff;
      cnt_in       = cnt_ff;
      sum_in       = sum_ff;
      ok_in        = ok_ff;
      idx_in       = idx_ff;
      rep_cnt_in   = rep_cnt_ff;
      rep_short_in = rep_short_ff;
      if (cmd.load_len) begin
         len_in = rx_byte[CNT_W-1:0];
         sum_in = rx_byte;
         cnt_in = '0;
      end
      if (cmd.store_byte) begin
         cnt_in = cnt_ff + CNT_W'(1);
         sum_in = sum_ff + rx_byte;
      end
      if (cmd.short_start) begin
         cnt_in = '0;
         ok_in  = 1'b1;
      end
      if (cmd.short_byte) begin
         cnt_in = cnt_ff + CNT_W'(1);
         ok_in  = ok_ff && chk_pos;
      end
      if (cmd.clr_count) begin
         cnt_in = '0;
      end
      if (cmd.start_replay) begin
         idx_in       = '0;
         rep_short_in = cmd.replay_short;
         rep_cnt_in   = cmd.replay_short ? CNT_W'(SHORT_LEN) : len_ff;
      end
      if (cmd.emit_payload) begin
         idx_in = idx_ff + IDX_W'(1);
      end
   end

   always_comb begin
      kind_in   = kind_ff;
      data_in   = data_ff;
      oidx_in   = oidx_ff;
      oshort_in = oshort_ff;
      code_in   = code_ff;
      last_in   = last_ff;
      valid_in  = rsp_tready ? 1'b0 : valid_ff;
      if (cmd.emit_err) begin
         valid_in  = 1'b1;
         kind_in   = 1'b1;
         data_in   = '0;
         oidx_in   = '0;
         oshort_in = 1'b0;
         code_in   = cmd.err_code;
         last_in   = 1'b1;
      end else if (cmd.emit_payload) begin
         valid_in  = 1'b1;
         kind_in   = 1'b0;
         data_in   = ram_rd;
         oidx_in   = idx_ff;
         oshort_in = rep_short_ff;
         code_in   = ERR_HEADER;
         last_in   = status.replay_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff   <= '0;
         cnt_ff   <= '0;
         sum_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         len_ff   <= len_in;
         cnt_ff   <= cnt_in;
         sum_ff   <= sum_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ok_ff        <= ok_in;
      idx_ff       <= idx_in;
      rep_cnt_ff   <= rep_cnt_in;
      rep_short_ff <= rep_short_in;
      kind_ff      <= kind_in;
      data_ff      <= data_in;
      oidx_ff      <= oidx_in;
      oshort_ff    <= oshort_in;
      code_ff      <= code_in;
      last_ff      <= last_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {6'd0, code_ff, oshort_ff, oidx_ff, data_ff};
   assign rsp_tuser  = kind_ff;
   assign rsp_tlast  = last_ff;

   a_load_free : assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_err || cmd.emit_payload) |-> status.out_free)
      else $error("result register loaded while occupied");

   a_one_load : assert property (@(posedge clock) disable iff (reset)
      !(cmd.emit_err && cmd.emit_payload))
      else $error("error and payload loaded together");

   a_idx_range : assert property (@(posedge clock) disable iff (reset)
      cmd.emit_payload |-> ({1'b0, idx_ff} < rep_cnt_ff))
      else $error("replay index past frame length");

   a_replay_start : assert property (@(posedge clock) disable iff (reset)
      cmd.start_replay |=> (idx_ff == '0) && (rep_cnt_ff != '0))
      else $error("replay started with bad index or count");

endmodule

`default_nettype wire

/* sv/sfr_ctrl.sv */
// ----------------------------------------------------------------------------
// sfr_ctrl
// Parser and replay state machine; drives datapath commands.
// ----------------------------------------------------------------------------
`default_nettype none

module sfr_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   input  wire sfr_pkg::status_type status,
   output sfr_pkg::cmd_type         cmd
);

   import sfr_pkg::*;

   state_type state_ff, state_in;
   logic      disc_ff, disc_in;
   logic      accept;

   always_comb begin
      req_tready = status.out_free && (state_ff != ST_FETCH) && (state_ff != ST_EMIT);
      accept     = req_tvalid && req_tready;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_HEADER: begin
            if (accept) begin
               if (status.is_v) begin
                  state_in = ST_VERSION;
               end else if (status.is_at) begin
                  state_in = ST_SHORT;
               end
            end
         end
         ST_VERSION: begin
            if (accept) begin
               if (status.is_one) begin
                  state_in = ST_LENGTH;
               end else if (!status.is_v) begin
                  state_in = ST_HEADER;
               end
            end
         end
         ST_LENGTH: begin
            if (accept) begin
               if (status.len_big) begin
                  state_in = ST_HEADER;
               end else if (status.len_zero) begin
                  state_in = ST_CHECK;
               end else begin
                  state_in = ST_DATA;
               end
            end
         end
         ST_DATA: begin
            if (accept) begin
               if (status.data_full) begin
                  state_in = ST_HEADER;
               end else if (status.data_done) begin
                  state_in = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            if (accept) begin
               if (status.sum_ok && !status.frame_len_zero) begin
                  state_in = ST_FETCH;
               end else begin
                  state_in = ST_HEADER;
               end
            end
         end
         ST_SHORT: begin
            if (accept && status.short_done) begin
               state_in = status.short_good ? ST_FETCH : ST_HEADER;
            end
         end
         ST_FETCH: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.out_free) begin
               state_in = status.replay_last ? ST_HEADER : ST_FETCH;
            end
         end
         default: begin
            state_in = ST_HEADER;
         end
      endcase
   end

   always_comb begin
      cmd      = '0;
      cmd.err_code = ERR_HEADER;
      disc_in  = disc_ff;
      unique case (state_ff)
         ST_HEADER: begin
            if (accept) begin
               if (status.is_v) begin
                  disc_in = 1'b0;
               end else if (status.is_at) begin
                  disc_in         = 1'b0;
                  cmd.short_start = 1'b1;
               end else if (!disc_ff) begin
                  disc_in      = 1'b1;
                  cmd.emit_err = 1'b1;
                  cmd.err_code = ERR_HEADER;
               end
            end
         end
         ST_VERSION: begin
            if (accept && !status.is_one && !status.is_v) begin
               cmd.emit_err = 1'b1;
               cmd.err_code = ERR_VERSION;
            end
         end
         ST_LENGTH: begin
            if (accept) begin
               if (status.len_big) begin
                  cmd.emit_err = 1'b1;
                  cmd.err_code = ERR_LENGTH;
               end else begin
                  cmd.load_len = 1'b1;
               end
            end
         end
         ST_DATA: begin
            if (accept) begin
               if (status.data_full) begin
                  cmd.clr_count = 1'b1;
               end else begin
                  cmd.store_byte = 1'b1;
               end
            end
         end
         ST_CHECK: begin
            if (accept) begin
               if (!status.sum_ok) begin
                  cmd.emit_err = 1'b1;
                  cmd.err_code = ERR_CHECKSUM;
               end else if (!status.frame_len_zero) begin
                  cmd.start_replay = 1'b1;
               end
            end
         end
         ST_SHORT: begin
            if (accept) begin
               cmd.short_byte = 1'b1;
               if (status.short_done) begin
                  if (status.short_good) begin
                     cmd.start_replay = 1'b1;
                     cmd.replay_short = 1'b1;
                  end else begin
                     cmd.emit_err = 1'b1;
                     cmd.err_code = ERR_SHORT;
                  end
               end
            end
         end
         ST_FETCH: begin
         end
         ST_EMIT: begin
            cmd.emit_payload = status.out_free;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_HEADER;
         disc_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         disc_ff  <= disc_in;
      end
   end

   a_no_take_in_replay : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FETCH || state_ff == ST_EMIT) |-> !req_tready)
      else $error("input taken during replay");

   a_fetch_then_emit : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FETCH) |=> (state_ff == ST_EMIT))
      else $error("fetch not followed by emit");

endmodule

`default_nettype wire

/* sv/serial_frame_receiver.sv */
// ----------------------------------------------------------------------------
// serial_frame_receiver
// Length-prefixed and short frame parser with buffered payload replay.
// ----------------------------------------------------------------------------
// Throughput: one received byte per cycle while parsing a frame and the output is free.
// Errors: an error result is registered in the cycle after its byte is taken.
// Replay: after a good checksum or third short letter, each payload byte gets a
//   buffer read, then a result load when the output is free; no input is taken until done.
// Reset: synchronous; clears parser state and result valid, not the buffer.
`default_nettype none

module serial_frame_receiver #(
   parameter int MaxPayload = sfr_pkg::MAX_PAYLOAD
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // rx_byte
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,   // payload_byte, byte_index, short_frame, error_code
   output logic             rsp_tuser,   // out_kind
   output logic             rsp_tlast    // last
);

   import sfr_pkg::*;

   cmd_type    cmd;
   status_type status;

   sfr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   sfr_dpath #(
      .MaxPayload (MaxPayload)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .rx_byte    (req_tdata),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

/* tb/serial_frame_receiver_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// serial_frame_receiver_tb
// Self-checking bench for the serial frame receiver: a directed table of
// header, version, length, checksum and short frame cases, then random full
// and short frames mixed with broken sequences and noise. Every result is
// compared field by field against a behavioral parser model, with random
// stalls on both streams.
// ----------------------------------------------------------------------------

module serial_frame_receiver_tb;
   import sfr_pkg::*;

   typedef struct packed {
      logic       kind;
      logic [7:0] data;
      logic [5:0] index;
      logic       short_frame;
      logic [2:0] code;
      logic       last;
   } frame_rsp_type;

   typedef struct {
      logic [7:0]   data;
      bit           fixed;
      err_code_type code;
   } rx_step_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;   // rx_byte
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;           // payload_byte, byte_index, short_frame, error_code
   logic        rsp_tuser;           // out_kind
   logic        rsp_tlast;           // last

   // parser model state
   state_type   parse_state = ST_HEADER;
   bit          discarding = 1'b0;
   logic [7:0]  frame_len = 8'h00;
   logic [6:0]  rx_count = 7'h00;
   logic [7:0]  frame_sum = 8'h00;
   logic [7:0]  frame_buf [MAX_PAYLOAD];

   frame_rsp_type pending_rsp [$];
   int          predicted_total = 0;
   int          mismatch_count = 0;
   int          bytes_taken = 0;
   int          stall_left = 0;
   bit          calm = 1'b0;

   logic [7:0]  first_letters [3] = '{CH_W, CH_D, CH_F};
   logic [7:0]  third_letters [6] = '{CH_LF, CH_LB, CH_LL, CH_LR, CH_LW, CH_LS};

   rx_step_type directed_steps [25] = '{
      '{8'h41,  1'b1, ERR_HEADER},
      '{8'hff,  1'b0, ERR_HEADER},
      '{CH_V,   1'b0, ERR_HEADER},
      '{8'h00,  1'b1, ERR_VERSION},
      '{CH_V,   1'b0, ERR_HEADER},
      '{CH_V,   1'b0, ERR_HEADER},
      '{CH_ONE, 1'b0, ERR_HEADER},
      '{8'd65,  1'b1, ERR_LENGTH},
      '{CH_V,   1'b0, ERR_HEADER},
      '{CH_ONE, 1'b0, ERR_HEADER},
      '{8'h01,  1'b0, ERR_HEADER},
      '{8'hff,  1'b0, ERR_HEADER},
      '{8'h01,  1'b1, ERR_CHECKSUM},
      '{CH_V,   1'b0, ERR_HEADER},
      '{CH_ONE, 1'b0, ERR_HEADER},
      '{8'h00,  1'b0, ERR_HEADER},
      '{8'h00,  1'b0, ERR_HEADER},
      '{CH_AT,  1'b0, ERR_HEADER},
      '{CH_D,   1'b0, ERR_HEADER},
      '{CH_4,   1'b0, ERR_HEADER},
      '{CH_LS,  1'b0, ERR_HEADER},
      '{CH_AT,  1'b0, ERR_HEADER},
      '{CH_F,   1'b0, ERR_HEADER},
      '{8'h30,  1'b0, ERR_HEADER},
      '{CH_LW,  1'b1, ERR_SHORT}
   };

   serial_frame_receiver dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #1 clock = ~clock;

   function automatic void push_error(input err_code_type code);
      pending_rsp.push_back('{kind: 1'b1, data: 8'h00, index: 6'd0, short_frame: 1'b0,
                              code: code, last: 1'b1});
      predicted_total++;
      parse_state = ST_HEADER;
   endfunction

   function automatic void push_replay(input int count, input logic is_short);
      for (int i = 0; i < count; i++) begin
         pending_rsp.push_back('{kind: 1'b0, data: frame_buf[i], index: i[5:0],
                                 short_frame: is_short, code: 3'd0,
                                 last: (i + 1 == count)});
         predicted_total++;
      end
      parse_state = ST_HEADER;
   endfunction

   // advance the parser by one byte; returns 1 when the byte is dropped silently
   function automatic bit parse_byte(input logic [7:0] c);
      bit dropped;
      dropped = 1'b0;
      case (parse_state)
         ST_VERSION: begin
            if (c == CH_ONE) parse_state = ST_LENGTH;
            else if (c != CH_V) push_error(ERR_VERSION);
         end
         ST_LENGTH: begin
            if (int'(c) > MAX_PAYLOAD) begin
               push_error(ERR_LENGTH);
            end else begin
               frame_len = c;
               frame_sum = c;
               rx_count = 7'd0;
               parse_state = (c == 8'd0) ? ST_CHECK : ST_DATA;
            end
         end
         ST_DATA: begin
            if (int'(rx_count) >= MAX_PAYLOAD) begin
               parse_state = ST_HEADER;
               rx_count = 7'd0;
            end else begin
               frame_buf[rx_count[5:0]] = c;
               rx_count = rx_count + 7'd1;
               frame_sum = frame_sum + c;
               if ({1'b0, rx_count} == frame_len) parse_state = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (frame_sum != c) push_error(ERR_CHECKSUM);
            else push_replay(int'(frame_len), 1'b0);
         end
         ST_SHORT: begin
            frame_buf[rx_count[1:0]] = c;
            rx_count = rx_count + 7'd1;
            if (rx_count >= 7'd3) begin
               if ((frame_buf[0] == CH_W || frame_buf[0] == CH_D || frame_buf[0] == CH_F) &&
                   (frame_buf[1] >= CH_ONE && frame_buf[1] <= CH_4) &&
                   (frame_buf[2] == CH_LF || frame_buf[2] == CH_LB ||
                    frame_buf[2] == CH_LL || frame_buf[2] == CH_LR ||
                    frame_buf[2] == CH_LW || frame_buf[2] == CH_LS))
                  push_replay(3, 1'b1);
               else
                  push_error(ERR_SHORT);
            end
         end
         default: begin
            if (c == CH_V) begin
               discarding = 1'b0;
               parse_state = ST_VERSION;
            end else if (c == CH_AT) begin
               discarding = 1'b0;
               rx_count = 7'd0;
               parse_state = ST_SHORT;
            end else if (discarding) begin
               parse_state = ST_HEADER;
               dropped = 1'b1;
            end else begin
               discarding = 1'b1;
               push_error(ERR_HEADER);
            end
         end
      endcase
      return dropped;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("[%0t] mismatch %s: got %0h expected %0h", $time, what, got, want);
      mismatch_count++;
   endtask

   // hold the byte until it is taken, then advance the model
   task automatic send_byte(input logic [7:0] value);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 6);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= value;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (!parse_byte(value)) bytes_taken++;
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      int w;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
      end else if (rsp_tready) begin
         if (rsp_tvalid) begin
            w = calm ? 0 : $urandom_range(0, 6);
            if (w != 0) begin
               rsp_tready <= 1'b0;
               stall_left <= w;
            end
         end
      end else if (stall_left > 1) begin
         stall_left <= stall_left - 1;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      frame_rsp_type got;
      frame_rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{kind: rsp_tuser, data: rsp_tdata[7:0], index: rsp_tdata[13:8],
                 short_frame: rsp_tdata[14], code: rsp_tdata[17:15], last: rsp_tlast};
         if (pending_rsp.size() == 0) begin
            report_mismatch("unexpected transfer", int'(got), 0);
         end else begin
            want = pending_rsp.pop_front();
            if (got.kind != want.kind) report_mismatch("out_kind", got.kind, want.kind);
            if (got.data != want.data) report_mismatch("payload_byte", got.data, want.data);
            if (got.index != want.index) report_mismatch("byte_index", got.index, want.index);
            if (got.short_frame != want.short_frame)
               report_mismatch("short_frame", got.short_frame, want.short_frame);
            if (got.code != want.code) report_mismatch("error_code", got.code, want.code);
            if (got.last != want.last) report_mismatch("last", got.last, want.last);
            if (rsp_tdata[23:18] != 6'd0) report_mismatch("pad bits", rsp_tdata[23:18], 0);
         end
      end
   end

   initial begin
      int         prior_total;
      int         seq_count;
      int         len;
      int         pick;
      logic [7:0] sum;
      logic [7:0] b;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_steps[i]) begin
         prior_total = predicted_total;
         send_byte(directed_steps[i].data);
         if (directed_steps[i].fixed) begin
            repeat (predicted_total - prior_total) void'(pending_rsp.pop_back());
            pending_rsp.push_back('{kind: 1'b1, data: 8'h00, index: 6'd0,
                                    short_frame: 1'b0, code: directed_steps[i].code,
                                    last: 1'b1});
         end
      end

      drain_results();
      bytes_taken = 0;
      seq_count = 0;
      while (bytes_taken < 410) begin
         calm = ($urandom_range(0, 5) == 0);
         if (seq_count % 40 == 39) drain_results();
         pick = (seq_count == 0) ? 0 : $urandom_range(0, 99);
         if (pick < 55) begin
            // full frame, mostly short payloads
            if (seq_count == 0) len = MAX_PAYLOAD;
            else if ($urandom_range(0, 24) == 0) len = $urandom_range(9, MAX_PAYLOAD);
            else len = $urandom_range(0, 8);
            sum = len[7:0];
            send_byte(CH_V);
            if ($urandom_range(0, 5) == 0) send_byte(CH_V);
            send_byte(CH_ONE);
            send_byte(len[7:0]);
            for (int i = 0; i < len; i++) begin
               b = 8'($urandom_range(0, 255));
               sum = sum + b;
               send_byte(b);
            end
            if ($urandom_range(0, 7) == 0) sum = sum ^ 8'($urandom_range(1, 255));
            send_byte(sum);
         end else if (pick < 75) begin
            send_byte(CH_AT);
            b = first_letters[$urandom_range(0, 2)];
            send_byte(($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255)) : b);
            b = CH_ONE + 8'($urandom_range(0, 3));
            send_byte(($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255)) : b);
            b = third_letters[$urandom_range(0, 5)];
            send_byte(($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255)) : b);
         end else if (pick < 85) begin
            send_byte(CH_V);
            send_byte(CH_ONE);
            send_byte(8'($urandom_range(MAX_PAYLOAD + 1, 255)));
         end else if (pick < 92) begin
            send_byte(CH_V);
            do b = 8'($urandom_range(0, 255)); while (b == CH_ONE || b == CH_V);
            send_byte(b);
         end else begin
            repeat ($urandom_range(1, 5)) send_byte(8'($urandom_range(0, 255)));
         end
         seq_count++;
      end

      calm = 1'b0;
      drain_results();
      repeat (200) @(posedge clock);
      if (mismatch_count == 0 && pending_rsp.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #400000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
